// ===== rtl/core/tpe_pkg.sv =====
`default_nettype none

package tpe_pkg;

    localparam int BYTE_W   = 8;
    localparam int BAUD_W   = 22;
    localparam int LINES_W  = 12;
    localparam int COUNT_W  = 16;
    localparam int TOTAL_W  = 32;
    localparam int WHOLE_W  = 32;
    localparam int TENTHS_W = 36;   // whole*10 + tenth
    localparam int PROD_W   = TENTHS_W + LINES_W;
    localparam int T_W      = 41;   // tenths after clamping to 2^40
    localparam int B10_W    = 19;   // baud/10
    localparam int ACC_W    = 26;   // holds the run limit
    localparam int STEP_W   = 6;
    localparam int BAUD_PROD_W = 44;
    localparam int CFG_IDX_W   = 2;

    localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CH_LESS    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GREATER = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

    localparam logic [T_W-1:0]   T_CLAMP   = 41'h100_0000_0000;
    // floor(x/1000) >= 65536 exactly when x >= 65536*1000
    localparam logic [ACC_W-1:0] RUN_LIMIT = 26'd65536000;
    // x/10 == (x * RECIP10) >> 25 for every 22-bit x
    localparam logic [BAUD_W-1:0] RECIP10  = 22'd3355444;
    localparam int RECIP10_SHIFT = 25;
    // x/1000 == (x * RECIP1000) >> 36 for every 26-bit x
    localparam int RECIP1000_W = 27;
    localparam logic [RECIP1000_W-1:0] RECIP1000 = 27'd68719477;
    localparam int RECIP1000_SHIFT = 36;
    localparam int QPROD_W = ACC_W + RECIP1000_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BAUD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD    = 2'd3;

    typedef enum logic [1:0] {
        OP_LIT  = 2'd0,
        OP_HOLD = 2'd1,
        OP_PAD  = 2'd2
    } op_t;

    // One command per input transaction: optional flush, main action,
    // optional flush at end of string.
    typedef struct packed {
        logic                pre_flush;
        logic                post_flush;
        logic                last;
        op_t                 op;
        logic [BYTE_W-1:0]   data;
        logic                star;
        logic [LINES_W-1:0]  lines;
        logic [TENTHS_W-1:0] w10;
    } cmd_t;

    typedef struct packed {
        logic [BAUD_W-1:0] baud;
        logic [BAUD_W-1:0] thresh;
        logic              flow_on;
        logic [BYTE_W-1:0] pad_byte;
    } cfg_t;

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tpe_front.sv =====
`default_nettype none

module tpe_front #(
    parameter int SPEC_DEPTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [tpe_pkg::BYTE_W-1:0]      in_byte,
    input  wire logic                            in_eos,
    input  wire logic [tpe_pkg::LINES_W-1:0]     in_lines,
    output logic                                 cmd_push,
    output tpe_pkg::cmd_t                        cmd_data,
    input  wire logic                            cmd_full,
    output logic [$clog2(SPEC_DEPTH+1)-1:0]      fill_out
);
    import tpe_pkg::*;

    localparam int CNT_W = $clog2(SPEC_DEPTH + 1);

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_DOLLAR = 6'b000010,
        PH_LESS   = 6'b000100,
        PH_WHOLE  = 6'b001000,
        PH_TENTH  = 6'b010000,
        PH_REST   = 6'b100000
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [WHOLE_W-1:0]   whole_reg, whole_next;
    logic [3:0]           tenth_reg, tenth_next;
    logic                 dot_reg, dot_next;
    logic                 star_reg, star_next;

    logic                 dig;
    logic [3:0]           dval;
    logic [TENTHS_W-1:0]  whole_x10;
    logic [TENTHS_W-1:0]  close_x10;
    logic                 go_outside;
    cmd_t                 cmd;

    assign in_ready = !cmd_full;
    assign cmd_push = in_valid && !cmd_full;
    assign cmd_data = cmd;
    assign fill_out = fill_reg;

    assign dig  = is_digit(in_byte);
    assign dval = 4'(in_byte - CH_ZERO);
    assign whole_x10 = (TENTHS_W'(whole_reg) << 3) + (TENTHS_W'(whole_reg) << 1)
                     + TENTHS_W'(dval);
    assign close_x10 = (TENTHS_W'(whole_reg) << 3) + (TENTHS_W'(whole_reg) << 1)
                     + TENTHS_W'(tenth_reg);

    always_comb begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        whole_next = whole_reg;
        tenth_next = tenth_reg;
        dot_next   = dot_reg;
        star_next  = star_reg;
        go_outside = 1'b0;
        cmd            = '0;
        cmd.op         = OP_LIT;
        cmd.data       = in_byte;
        cmd.lines      = in_lines;
        cmd.star       = star_reg;
        cmd.w10        = close_x10;

        unique case (phase_reg)
            PH_DOLLAR: begin
                if (in_byte == CH_LESS) begin
                    cmd.op     = OP_HOLD;
                    fill_next  = fill_reg + CNT_W'(1);
                    phase_next = PH_LESS;
                end else begin
                    cmd.pre_flush = 1'b1;
                    go_outside    = 1'b1;
                end
            end
            PH_LESS: begin
                if (dig) begin
                    cmd.op     = OP_HOLD;
                    fill_next  = fill_reg + CNT_W'(1);
                    whole_next = WHOLE_W'(dval);
                    phase_next = PH_WHOLE;
                end else if (in_byte == CH_DOT) begin
                    cmd.op     = OP_HOLD;
                    fill_next  = fill_reg + CNT_W'(1);
                    dot_next   = 1'b1;
                    phase_next = PH_TENTH;
                end else begin
                    cmd.pre_flush = 1'b1;
                    go_outside    = 1'b1;
                end
            end
            PH_WHOLE, PH_TENTH, PH_REST: begin
                if (in_byte == CH_GREATER) begin
                    cmd.op     = OP_PAD;
                    phase_next = PH_IDLE;
                    fill_next  = '0;
                    whole_next = '0;
                    tenth_next = '0;
                    dot_next   = 1'b0;
                    star_next  = 1'b0;
                end else if (fill_reg >= CNT_W'(SPEC_DEPTH)) begin
                    // spec buffer overflow
                    cmd.pre_flush = 1'b1;
                    go_outside    = 1'b1;
                end else begin
                    cmd.op    = OP_HOLD;
                    fill_next = fill_reg + CNT_W'(1);
                    if (phase_reg == PH_WHOLE) begin
                        if (dig) begin
                            whole_next = (whole_x10[TENTHS_W-1:WHOLE_W] != '0) ? '1
                                       : whole_x10[WHOLE_W-1:0];
                        end else if (in_byte == CH_DOT) begin
                            dot_next   = 1'b1;
                            phase_next = PH_TENTH;
                        end else begin
                            phase_next = PH_REST;
                        end
                    end else if (phase_reg == PH_TENTH) begin
                        if (dig) begin
                            tenth_next = dval;
                        end
                        phase_next = PH_REST;
                    end else if (in_byte == CH_DOT && !dot_reg) begin
                        dot_next   = 1'b1;
                        phase_next = PH_TENTH;
                    end
                    star_next = (in_byte == CH_STAR);
                end
            end
            default: begin
                go_outside = 1'b1;
            end
        endcase

        if (go_outside) begin
            whole_next = '0;
            tenth_next = '0;
            dot_next   = 1'b0;
            star_next  = 1'b0;
            if (in_byte == CH_DOLLAR) begin
                cmd.op     = OP_HOLD;
                fill_next  = CNT_W'(1);
                phase_next = PH_DOLLAR;
            end else begin
                cmd.op     = OP_LIT;
                fill_next  = '0;
                phase_next = PH_IDLE;
            end
        end

        if (in_eos) begin
            cmd.post_flush = (fill_next != '0);
            cmd.last       = 1'b1;
            phase_next = PH_IDLE;
            fill_next  = '0;
            whole_next = '0;
            tenth_next = '0;
            dot_next   = 1'b0;
            star_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            fill_reg  <= '0;
            whole_reg <= '0;
            tenth_reg <= '0;
            dot_reg   <= 1'b0;
            star_reg  <= 1'b0;
        end else if (cmd_push) begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            whole_reg <= whole_next;
            tenth_reg <= tenth_next;
            dot_reg   <= dot_next;
            star_reg  <= star_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tpe_cmd_queue.sv =====
`default_nettype none

module tpe_cmd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire tpe_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output tpe_pkg::cmd_t      head_data
);
    import tpe_pkg::*;

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tpe_back.sv =====
`default_nettype none

module tpe_back #(
    parameter int SPEC_DEPTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cmd_valid,
    input  wire tpe_pkg::cmd_t                   cmd_data,
    output logic                                 cmd_pop,
    input  wire tpe_pkg::cfg_t                   cfg,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [tpe_pkg::BYTE_W-1:0]           out_byte,
    output logic [tpe_pkg::COUNT_W-1:0]          out_count,
    output logic [tpe_pkg::TOTAL_W-1:0]          out_total,
    output logic                                 out_last,
    output logic                                 idle,
    output logic [$clog2(SPEC_DEPTH+1)-1:0]      fill_out
);
    import tpe_pkg::*;

    localparam int CNT_W = $clog2(SPEC_DEPTH + 1);
    localparam int IDX_W = $clog2(SPEC_DEPTH);

    typedef enum logic [7:0] {
        BK_IDLE     = 8'b00000001,
        BK_FL_RD    = 8'b00000010,
        BK_FL_EMIT  = 8'b00000100,
        BK_MAIN     = 8'b00001000,
        BK_PAD_MUL  = 8'b00010000,
        BK_PAD_SER  = 8'b00100000,
        BK_PAD_DIV  = 8'b01000000,
        BK_PAD_EMIT = 8'b10000000
    } bstate_t;

    bstate_t              state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic                 post_reg, post_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [BYTE_W-1:0]    rd_data_reg;
    logic [BYTE_W-1:0]    mem [SPEC_DEPTH];
    logic [T_W-1:0]       t_reg, t_next;
    logic [B10_W-1:0]     b10_reg, b10_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [COUNT_W-1:0]   run_reg, run_next;
    logic [TOTAL_W-1:0]   len_reg;

    logic                 ov_reg;
    logic [BYTE_W-1:0]    ob_reg;
    logic [COUNT_W-1:0]   oc_reg;
    logic [TOTAL_W-1:0]   ot_reg;
    logic                 ol_reg;

    logic                 slot_free;
    logic                 mem_we;
    logic                 emit_go;
    logic [BYTE_W-1:0]    emit_byte;
    logic [COUNT_W-1:0]   emit_cnt;
    logic                 emit_last;
    logic [TOTAL_W:0]     len_sum;
    logic [TOTAL_W-1:0]   len_sat;

    logic                 pad_on;
    logic [PROD_W-1:0]    prod_lines;
    logic [PROD_W-1:0]    tenths;
    logic [BAUD_PROD_W-1:0] baud_prod;
    logic [B10_W-1:0]     ser_add;
    logic [ACC_W+1:0]     ser_sum;
    logic [QPROD_W-1:0]   quot_prod;
    logic                 last_elem;

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_count = oc_reg;
    assign out_total = ot_reg;
    assign out_last  = ol_reg;
    assign idle      = (state_reg == BK_IDLE);
    assign fill_out  = fill_reg;

    assign slot_free = !ov_reg || out_ready;
    assign len_sum   = {1'b0, len_reg} + (TOTAL_W+1)'(emit_cnt);
    assign len_sat   = len_sum[TOTAL_W] ? '1 : len_sum[TOTAL_W-1:0];

    assign pad_on     = (cfg.thresh != '0) && (cfg.baud >= cfg.thresh) && !cfg.flow_on;
    assign prod_lines = PROD_W'(cmd_reg.w10) * PROD_W'(cmd_reg.lines);
    assign tenths     = cmd_reg.star ? prod_lines : PROD_W'(cmd_reg.w10);
    assign baud_prod  = BAUD_PROD_W'(cfg.baud) * BAUD_PROD_W'(RECIP10);
    assign ser_add    = t_reg[T_W-1] ? b10_reg : '0;
    assign ser_sum    = {1'b0, acc_reg, 1'b0} + (ACC_W+2)'(ser_add);
    assign quot_prod  = QPROD_W'(acc_reg) * QPROD_W'(RECIP1000);
    assign last_elem  = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == fill_reg;

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        post_next   = post_reg;
        fill_next   = fill_reg;
        rd_idx_next = rd_idx_reg;
        t_next      = t_reg;
        b10_next    = b10_reg;
        acc_next    = acc_reg;
        step_next   = step_reg;
        run_next    = run_reg;
        cmd_pop     = 1'b0;
        mem_we      = 1'b0;
        emit_go     = 1'b0;
        emit_byte   = '0;
        emit_cnt    = '0;
        emit_last   = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_data;
                    post_next  = 1'b0;
                    state_next = cmd_data.pre_flush ? BK_FL_RD : BK_MAIN;
                end
            end
            BK_FL_RD: begin
                state_next = BK_FL_EMIT;
            end
            BK_FL_EMIT: begin
                if (slot_free) begin
                    emit_go   = 1'b1;
                    emit_byte = rd_data_reg;
                    emit_cnt  = COUNT_W'(1);
                    emit_last = post_reg && cmd_reg.last && last_elem;
                    if (last_elem) begin
                        fill_next   = '0;
                        rd_idx_next = '0;
                        state_next  = post_reg ? BK_IDLE : BK_MAIN;
                    end else begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = BK_FL_RD;
                    end
                end
            end
            BK_MAIN: begin
                case (cmd_reg.op)
                    OP_LIT: begin
                        if (slot_free) begin
                            emit_go    = 1'b1;
                            emit_byte  = cmd_reg.data;
                            emit_cnt   = COUNT_W'(1);
                            emit_last  = cmd_reg.last && !cmd_reg.post_flush;
                            post_next  = 1'b1;
                            state_next = cmd_reg.post_flush ? BK_FL_RD : BK_IDLE;
                        end
                    end
                    OP_HOLD: begin
                        mem_we     = 1'b1;
                        fill_next  = fill_reg + CNT_W'(1);
                        post_next  = 1'b1;
                        state_next = cmd_reg.post_flush ? BK_FL_RD : BK_IDLE;
                    end
                    OP_PAD: begin
                        // closing bracket drops the held spec bytes
                        fill_next  = '0;
                        state_next = BK_PAD_MUL;
                    end
                    default: begin
                        state_next = BK_IDLE;
                    end
                endcase
            end
            BK_PAD_MUL: begin
                t_next    = (tenths > PROD_W'(T_CLAMP)) ? T_CLAMP : tenths[T_W-1:0];
                b10_next  = baud_prod[RECIP10_SHIFT +: B10_W];
                acc_next  = '0;
                step_next = STEP_W'(T_W - 1);
                if (pad_on) begin
                    state_next = BK_PAD_SER;
                end else begin
                    run_next   = '0;
                    state_next = BK_PAD_EMIT;
                end
            end
            BK_PAD_SER: begin
                // MSB-first shift-add of baud/10 * tenths, clamped at the run limit
                acc_next = (ser_sum >= (ACC_W+2)'(RUN_LIMIT)) ? RUN_LIMIT
                         : ser_sum[ACC_W-1:0];
                t_next   = t_reg << 1;
                if (step_reg == '0) begin
                    state_next = BK_PAD_DIV;
                end else begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            BK_PAD_DIV: begin
                // divide by 1000 through the reciprocal; below the limit it fits 16 bits
                run_next   = (acc_reg >= RUN_LIMIT) ? '1
                           : quot_prod[RECIP1000_SHIFT +: COUNT_W];
                state_next = BK_PAD_EMIT;
            end
            BK_PAD_EMIT: begin
                if (run_reg == '0 && !cmd_reg.last) begin
                    state_next = BK_IDLE;
                end else if (slot_free) begin
                    emit_go    = 1'b1;
                    emit_byte  = (run_reg != '0) ? cfg.pad_byte : '0;
                    emit_cnt   = run_reg;
                    emit_last  = cmd_reg.last;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[fill_reg[IDX_W-1:0]] <= cmd_reg.data;
        end
        rd_data_reg <= mem[rd_idx_reg];
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        t_reg   <= t_next;
        b10_reg <= b10_next;
        acc_reg <= acc_next;
        run_reg <= run_next;
        if (emit_go) begin
            ob_reg <= emit_byte;
            oc_reg <= emit_cnt;
            ot_reg <= len_sat;
            ol_reg <= emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BK_IDLE;
            post_reg   <= 1'b0;
            fill_reg   <= '0;
            rd_idx_reg <= '0;
            step_reg   <= '0;
            len_reg    <= '0;
            ov_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            post_reg   <= post_next;
            fill_reg   <= fill_next;
            rd_idx_reg <= rd_idx_next;
            step_reg   <= step_next;
            if (emit_go) begin
                ov_reg  <= 1'b1;
                len_reg <= emit_last ? '0 : len_sat;
            end else if (out_ready) begin
                ov_reg  <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/terminal_padding_expander_core.sv =====
`default_nettype none

// Expands the padding specs of a terminal control string. Bytes arrive one per
// transaction on the s_ side; s_tlast marks the last byte of a string. Ordinary
// bytes come out as results with repeat count 1, a "$<tenths[*]>" spec becomes
// one pad-byte run, and held spec bytes that never close are replayed as
// literals. The final result of each string carries m_tlast, and the running
// total restarts after it. A parser front end takes one transaction per cycle
// into a two-entry command queue unless the queue is full; the back end runs
// one command at a time: a literal is a command fetch and an output, each
// replayed spec byte a registered buffer read plus output, and a pad run a
// command fetch and decode, a multiply, 41 shift-add steps for baud/10 times
// tenths, a reciprocal divide-by-1000 and an output, skipping shift-add and
// divide when padding is off.
// Configuration: cfg_index 0 baud rate, 1 padding threshold (0 disables),
// 2 xon/xoff flag, 3 pad byte; write only while the block is idle.
module terminal_padding_expander_core #(
    parameter int SPEC_DEPTH = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [23:0]                        s_tdata,  // in_byte, affected_lines
    input  wire logic                               s_tlast,  // end_of_string
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [55:0]                             m_tdata,  // out_byte, repeat_count,
                                                              // total_length
    output logic                                    m_tlast,  // is_last
    input  wire logic                               cfg_wr_en,
    input  wire logic [tpe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tpe_pkg::BAUD_W-1:0]         cfg_wdata
);
    import tpe_pkg::*;

    localparam int CNT_W = $clog2(SPEC_DEPTH + 1);

    cfg_t               cfg_reg;
    cmd_t               push_cmd;
    cmd_t               head_cmd;
    logic               push;
    logic               q_full;
    logic               head_valid;
    logic               pop;
    logic               back_idle;
    logic [CNT_W-1:0]   front_fill;
    logic [CNT_W-1:0]   back_fill;
    logic [BYTE_W-1:0]  r_byte;
    logic [COUNT_W-1:0] r_count;
    logic [TOTAL_W-1:0] r_total;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.baud     <= BAUD_W'(9600);
            cfg_reg.thresh   <= '0;
            cfg_reg.flow_on  <= 1'b0;
            cfg_reg.pad_byte <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BAUD:   cfg_reg.baud     <= cfg_wdata;
                CFG_THRESH: cfg_reg.thresh   <= cfg_wdata;
                CFG_FLOW:   cfg_reg.flow_on  <= cfg_wdata[0];
                CFG_PAD:    cfg_reg.pad_byte <= cfg_wdata[BYTE_W-1:0];
                default:    cfg_reg          <= cfg_reg;
            endcase
        end
    end

    tpe_front #(
        .SPEC_DEPTH (SPEC_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata[7:0]),
        .in_eos   (s_tlast),
        .in_lines (s_tdata[19:8]),
        .cmd_push (push),
        .cmd_data (push_cmd),
        .cmd_full (q_full),
        .fill_out (front_fill)
    );

    tpe_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_cmd)
    );

    tpe_back #(
        .SPEC_DEPTH (SPEC_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (head_valid),
        .cmd_data  (head_cmd),
        .cmd_pop   (pop),
        .cfg       (cfg_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (r_byte),
        .out_count (r_count),
        .out_total (r_total),
        .out_last  (m_tlast),
        .idle      (back_idle),
        .fill_out  (back_fill)
    );

    assign m_tdata = {r_total, r_count, r_byte};

    // an empty result only closes a string
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && r_count == '0) |-> m_tlast)
        else $error("zero-count result without last flag");

    // running total always covers the run just reported
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (r_total >= TOTAL_W'(r_count)))
        else $error("total length below repeat count");

    // once all commands are executed, parser and spec buffer agree on fill
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!head_valid && back_idle) |-> (front_fill == back_fill))
        else $error("spec fill mismatch between front and back");

endmodule

`default_nettype wire

// ===== verif/terminal_padding_expander_core_test.sv =====
`default_nettype none

module terminal_padding_expander_core_test;
    import tpe_pkg::*;

    localparam int HELD_MAX     = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES  = 500;
    localparam bit [63:0] TENTHS_CAP = 64'h100_0000_0000;

    typedef enum {
        SP_IDLE,
        SP_DOLLAR,
        SP_LESS,
        SP_WHOLE,
        SP_TENTH,
        SP_REST
    } spec_state_e;

    typedef struct packed {
        bit [7:0]  data;
        bit [15:0] count;
        bit [31:0] total;
        bit        last;
    } pad_result_t;

    class padding_scoreboard;
        bit [21:0]   baud_rate = 22'd9600;
        bit [21:0]   threshold;
        bit          flow_on;
        bit [7:0]    pad_value;
        spec_state_e state = SP_IDLE;
        bit [7:0]    held[$];
        bit [31:0]   whole;
        bit [3:0]    tenth;
        bit          dot_seen;
        bit          star_last;
        bit [31:0]   sent_length;
        pad_result_t step_results[$];
        pad_result_t expected[$];
        int          mismatches;

        function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [21:0] val);
            case (idx)
                CFG_BAUD:   baud_rate = val;
                CFG_THRESH: threshold = val;
                CFG_FLOW:   flow_on = val[0];
                CFG_PAD:    pad_value = val[7:0];
                default: ;
            endcase
        endfunction

        function bit is_numeral(bit [7:0] b);
            return b >= CH_ZERO && b <= CH_NINE;
        endfunction

        function void clear_spec();
            state = SP_IDLE;
            held.delete();
            whole = 0;
            tenth = 0;
            dot_seen = 0;
            star_last = 0;
        endfunction

        function void emit(bit [7:0] b, bit [15:0] cnt);
            pad_result_t r;
            bit [63:0] sum;
            sum = 64'(sent_length) + 64'(cnt);
            sent_length = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            r.data = b;
            r.count = cnt;
            r.total = sent_length;
            r.last = 1'b0;
            step_results.push_back(r);
        endfunction

        function void flush_held();
            foreach (held[i]) emit(held[i], 16'd1);
            clear_spec();
        endfunction

        function void plain_byte(bit [7:0] b);
            if (b == CH_DOLLAR) begin
                held.push_back(b);
                state = SP_DOLLAR;
            end else begin
                emit(b, 16'd1);
            end
        endfunction

        function void close_spec(bit [11:0] lines);
            bit [63:0] t;
            bit [63:0] run;
            t = 64'(whole) * 10 + 64'(tenth);
            if (star_last) t = t * 64'(lines);
            if (t > TENTHS_CAP) t = TENTHS_CAP;
            run = (64'(baud_rate / 10) * t) / 1000;
            if (run > 64'd65535) run = 64'd65535;
            if (threshold != 0 && baud_rate >= threshold && !flow_on && run != 0)
                emit(pad_value, run[15:0]);
            clear_spec();
        endfunction

        function void body_byte(bit [7:0] b);
            bit [63:0] w;
            if (state == SP_WHOLE) begin
                if (is_numeral(b)) begin
                    w = 64'(whole) * 10 + 64'(b - CH_ZERO);
                    whole = (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
                end else if (b == CH_DOT) begin
                    dot_seen = 1'b1;
                    state = SP_TENTH;
                end else begin
                    state = SP_REST;
                end
            end else if (state == SP_TENTH) begin
                if (is_numeral(b)) tenth = 4'(b - CH_ZERO);
                state = SP_REST;
            end else if (b == CH_DOT && !dot_seen) begin
                dot_seen = 1'b1;
                state = SP_TENTH;
            end
            star_last = (b == CH_STAR);
        endfunction

        function void note_input(bit [7:0] b, bit eos, bit [11:0] lines);
            step_results.delete();
            case (state)
                SP_DOLLAR: begin
                    if (b == CH_LESS) begin
                        held.push_back(b);
                        state = SP_LESS;
                    end else begin
                        flush_held();
                        plain_byte(b);
                    end
                end
                SP_LESS: begin
                    if (is_numeral(b)) begin
                        held.push_back(b);
                        whole = 32'(b - CH_ZERO);
                        state = SP_WHOLE;
                    end else if (b == CH_DOT) begin
                        held.push_back(b);
                        dot_seen = 1'b1;
                        state = SP_TENTH;
                    end else begin
                        flush_held();
                        plain_byte(b);
                    end
                end
                SP_WHOLE, SP_TENTH, SP_REST: begin
                    if (b == CH_GREATER) begin
                        close_spec(lines);
                    end else if (held.size() >= HELD_MAX) begin
                        // spec buffer full: replay it, byte starts fresh
                        flush_held();
                        plain_byte(b);
                    end else begin
                        held.push_back(b);
                        body_byte(b);
                    end
                end
                default: begin
                    clear_spec();
                    plain_byte(b);
                end
            endcase
            if (eos) begin
                if (held.size() > 0) flush_held();
                clear_spec();
                if (step_results.size() == 0) emit(8'h00, 16'd0);
                step_results[step_results.size() - 1].last = 1'b1;
                sent_length = 0;
            end
            foreach (step_results[i]) expected.push_back(step_results[i]);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 50) $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(bit [7:0] b, bit [15:0] cnt, bit [31:0] tot, bit last);
            pad_result_t want;
            if (expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result byte %02h count %0d", b, cnt));
                return;
            end
            want = expected.pop_front();
            if (b != want.data)
                report_mismatch($sformatf("out_byte %02h, want %02h", b, want.data));
            if (cnt != want.count)
                report_mismatch($sformatf("repeat_count %0d, want %0d", cnt, want.count));
            if (tot != want.total)
                report_mismatch($sformatf("total_length %0d, want %0d", tot, want.total));
            if (last != want.last)
                report_mismatch($sformatf("is_last %0b, want %0b", last, want.last));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;   // in_byte, affected_lines
    logic                 s_tlast   = 1'b0; // end_of_string
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [55:0]          m_tdata;          // out_byte, repeat_count, total_length
    logic                 m_tlast;          // is_last
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BAUD_W-1:0]    cfg_wdata = '0;

    padding_scoreboard sb;
    bit [7:0] text[$];
    int send_idle = 0;
    int recv_idle = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;

    terminal_padding_expander_core #(
        .SPEC_DEPTH(HELD_MAX)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[7:0], m_tdata[23:8], m_tdata[55:24], m_tlast);
    end

    function automatic bit [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic bit [7:0] rand_body_byte();
        bit [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == CH_GREATER);
        return b;
    endfunction

    function automatic bit [11:0] rand_lines();
        return $urandom_range(0, 1) ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 3));
    endfunction

    function automatic void add_token();
        int kind = $urandom_range(0, 99);
        int n;
        text.push_back(CH_DOLLAR);
        if (kind < 40) begin
            // well-formed spec, occasionally with enough digits to saturate
            text.push_back(CH_LESS);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 3);
            repeat (n) text.push_back(rand_digit());
            if (n == 0 || $urandom_range(0, 1)) begin
                text.push_back(CH_DOT);
                text.push_back(rand_digit());
            end
            if ($urandom_range(0, 2) == 0) text.push_back(CH_STAR);
            text.push_back(CH_GREATER);
        end else if (kind < 65) begin
            text.pop_back();
            repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(1, 255)));
        end else if (kind < 75) begin
            // broken opening
            if ($urandom_range(0, 1)) text.push_back(CH_LESS);
            text.push_back(8'($urandom_range(1, 255)));
        end else if (kind < 85) begin
            // never closed
            text.push_back(CH_LESS);
            repeat ($urandom_range(1, 2)) text.push_back(rand_digit());
            if ($urandom_range(0, 1)) text.push_back(CH_DOT);
        end else if (kind < 93) begin
            // fills or runs past the spec buffer
            text.push_back(CH_LESS);
            text.push_back(rand_digit());
            repeat ($urandom_range(13, 20)) text.push_back(rand_body_byte());
            if ($urandom_range(0, 1)) text.push_back(CH_GREATER);
        end else begin
            // odd bodies: extra dots, stray stars, junk after the dot
            text.push_back(CH_LESS);
            text.push_back($urandom_range(0, 1) ? CH_DOT : rand_digit());
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 3))
                    0: text.push_back(rand_digit());
                    1: text.push_back(CH_DOT);
                    2: text.push_back(CH_STAR);
                    default: text.push_back(rand_body_byte());
                endcase
            end
            text.push_back(CH_GREATER);
        end
    endfunction

    task automatic send_byte(input bit [7:0] b, input bit eos, input bit [11:0] lines);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, lines, b};
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(b, eos, lines);
    endtask

    task automatic send_text(input bit max_lines);
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1, max_lines ? 12'hFFF : rand_lines());
    endtask

    task automatic send_chars(input string s, input bit max_lines);
        text.delete();
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
        send_text(max_lines);
    endtask

    task automatic write_reg(input bit [CFG_IDX_W-1:0] idx, input bit [21:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic configure(input bit [21:0] baud, input bit [21:0] thr, input bit flow,
                             input bit [7:0] pad);
        write_reg(CFG_BAUD, baud);
        write_reg(CFG_THRESH, thr);
        write_reg(CFG_FLOW, 22'(flow));
        write_reg(CFG_PAD, 22'(pad));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_quiet();
        while (sb.expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random(input bit [21:0] baud, input bit [21:0] thr, input bit flow,
                              input bit [7:0] pad, input int s_idle, input int r_idle,
                              input int n_items, input bit hold_off);
        int sent = 0;
        configure(baud, thr, flow, pad);
        send_idle = s_idle;
        recv_idle = r_idle;
        if (hold_off) hold_request = 1'b1;
        while (sent < n_items) begin
            text.delete();
            repeat ($urandom_range(1, 5)) add_token();
            sent += text.size();
            send_text(1'b0);
        end
        s_tvalid <= 1'b0;
        wait_quiet();
    endtask

    initial begin
        bit [21:0] rbaud;
        sb = new;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        configure(22'd9600, 22'd1200, 1'b0, 8'h00);
        send_idle = 26;
        recv_idle = 83;
        send_chars("$<5>", 1'b0);
        send_chars("$<2.5*>", 1'b1);    // saturates the run
        send_chars("$x", 1'b0);
        send_chars("$<q", 1'b0);
        send_chars("$<0>", 1'b0);       // empty run, so an empty closing result
        send_chars("$<1.x>", 1'b0);
        text = '{8'h00};
        send_text(1'b0);
        s_tvalid <= 1'b0;
        wait_quiet();

        run_random(22'd38400, 22'd300, 1'b0, 8'hA5, 26, 83, 65, 1'b0);
        run_random(22'h3FFFFF, 22'h3FFFFF, 1'b0, 8'hFF, 26, 83, 60, 1'b0);
        run_random(22'd0, 22'd0, 1'b0, 8'h5A, 83, 26, 60, 1'b0);
        run_random(22'd115200, 22'd9600, 1'b1, 8'h11, 83, 26, 60, 1'b0);
        run_random(22'd2400, 22'h3FFFFF, 1'b0, 8'h22, 0, 0, 60, 1'b1);
        rbaud = 22'($urandom_range(1, 4194303));
        run_random(rbaud, 22'($urandom_range(1, rbaud)), 1'b0, 8'($urandom_range(0, 255)),
                   0, 0, 75, 1'b0);

        if (sb.mismatches == 0 && sb.expected.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
